FILE: rtl/salc_pkg.sv
// Shared types and constants of the set-associative LRU tag store.
// Used by every module of the block; depends on nothing.
`default_nettype none
package salc_pkg;

  localparam int DEF_MAX_SETS  = 64;
  localparam int DEF_MAX_WAYS  = 8;
  localparam int DEF_ADDR_BITS = 31;

  localparam int WAYS_CFG_W = 4;
  localparam int SETS_CFG_W = 7;
  localparam int WPB_CFG_W  = 16;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = WAYS_CFG_W'(1);
  localparam logic [SETS_CFG_W-1:0] SETS_RESET = SETS_CFG_W'(64);
  localparam logic [WPB_CFG_W-1:0]  WPB_RESET  = WPB_CFG_W'(1);

  typedef enum logic [1:0] {
    REG_WAYS = 2'd0,
    REG_SETS = 2'd1,
    REG_WPB  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [WAYS_CFG_W-1:0] ways;
    logic [SETS_CFG_W-1:0] sets;
    logic [WPB_CFG_W-1:0]  wpb;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/salc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Uses salc_pkg for the divisor width.
`default_nettype none
module salc_divider
  import salc_pkg::*;
#(
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 go,
  input  wire logic [ADDR_BITS-1:0] dividend,
  input  wire logic [WPB_CFG_W-1:0] divisor,
  output logic                      done,
  output logic [ADDR_BITS-1:0]      quotient,
  output logic [WPB_CFG_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(ADDR_BITS);

  logic                 running;
  logic [CNT_W-1:0]     cnt;
  logic [WPB_CFG_W-1:0] div_reg;
  logic [WPB_CFG_W:0]   rem_sh;
  logic [WPB_CFG_W:0]   diff;

  assign rem_sh = {remainder, quotient[ADDR_BITS-1]};
  assign diff   = rem_sh - {1'b0, div_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(ADDR_BITS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
      div_reg   <= divisor;
    end else if (running) begin
      if (!diff[WPB_CFG_W]) begin
        remainder <= diff[WPB_CFG_W-1:0];
        quotient  <= {quotient[ADDR_BITS-2:0], 1'b1};
      end else begin
        remainder <= rem_sh[WPB_CFG_W-1:0];
        quotient  <= {quotient[ADDR_BITS-2:0], 1'b0};
      end
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < div_reg))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

FILE: rtl/salc_front.sv
// Front end: accepts an address and splits it into set and tag with two
// passes through the shared divider. Uses salc_pkg and salc_divider.
`default_nettype none
module salc_front
  import salc_pkg::*;
#(
  parameter int MAX_SETS  = DEF_MAX_SETS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 hold,
  input  wire logic [ADDR_BITS-1:0] word_address,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_full,
  output logic                      q_push,
  output logic [ADDR_BITS-1:0]      q_tag,
  output logic [SET_W-1:0]          q_set,
  output logic                      front_busy
);

  typedef enum logic [1:0] {F_IDLE, F_DIV_BLOCK, F_DIV_SET, F_PUSH} fstate_t;

  localparam logic [WPB_CFG_W-1:0] MAX_SETS_D = WPB_CFG_W'(MAX_SETS);

  fstate_t                state;
  logic                   go;
  logic [ADDR_BITS-1:0]   dividend;
  logic [WPB_CFG_W-1:0]   divisor;
  logic                   done;
  logic [ADDR_BITS-1:0]   quotient;
  logic [WPB_CFG_W-1:0]   remainder;
  logic [WPB_CFG_W-1:0]   wpb_eff;
  logic [WPB_CFG_W-1:0]   sets_eff;
  logic [WPB_CFG_W-1:0]   sets_ext;

  assign sets_ext = WPB_CFG_W'(cfg.sets);
  assign wpb_eff  = (cfg.wpb == '0) ? WPB_CFG_W'(1) : cfg.wpb;
  assign sets_eff = (cfg.sets == '0) ? WPB_CFG_W'(1) :
                    (sets_ext > MAX_SETS_D) ? MAX_SETS_D : sets_ext;

  // The first pass divides by the block size, the second by the set count.
  assign go       = ((state == F_IDLE) && start && !hold) ||
                    ((state == F_DIV_BLOCK) && done);
  assign dividend = (state == F_IDLE) ? word_address : quotient;
  assign divisor  = (state == F_IDLE) ? wpb_eff : sets_eff;

  assign q_push     = (state == F_PUSH) && !q_full;
  assign q_tag      = quotient;
  assign q_set      = remainder[SET_W-1:0];
  assign front_busy = (state != F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start && !hold) state <= F_DIV_BLOCK;
        end
        F_DIV_BLOCK: begin
          if (done) state <= F_DIV_SET;
        end
        F_DIV_SET: begin
          if (done) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  salc_divider #(.ADDR_BITS(ADDR_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (done),
    .quotient  (quotient),
    .remainder (remainder)
  );

endmodule
`default_nettype wire

FILE: rtl/salc_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on salc_pkg for the default width.
`default_nettype none
module salc_queue
  import salc_pkg::*;
#(
  parameter int WIDTH = DEF_ADDR_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head  = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

FILE: rtl/salc_back.sv
// Back end: reads one set row, looks up the tag, picks the victim, updates
// recency and reports the word. Uses salc_pkg for the config struct.
`default_nettype none
module salc_back
  import salc_pkg::*;
#(
  parameter int MAX_SETS  = DEF_MAX_SETS,
  parameter int MAX_WAYS  = DEF_MAX_WAYS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 q_empty,
  input  wire logic [ADDR_BITS-1:0] q_tag,
  input  wire logic [SET_W-1:0]     q_set,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      done,
  output logic                      hit,
  output logic [SET_W-1:0]          set_number,
  output logic [WAY_W-1:0]          way_number
);

  localparam int RANK_W = WAY_W;
  localparam int OLD_W  = $clog2(MAX_WAYS + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EVAL} bstate_t;

  bstate_t state;
  logic [SET_W-1:0] clear_cnt;
  logic [SET_W-1:0] cur_set;
  logic [ADDR_BITS-1:0] cur_tag;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_mem  [MAX_SETS];

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_row;
  logic [MAX_WAYS-1:0]                valid_row;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    rank_row;

  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] new_tag;
  logic [MAX_WAYS-1:0]                new_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    new_rank;

  logic [MAX_WAYS-1:0] active;
  logic                ev_hit;
  logic                found_inv;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    lru_way;
  logic [WAY_W-1:0]    ev_way;
  logic [OLD_W-1:0]    old_rank;

  assign clearing = (state == B_CLEAR);
  assign q_pop    = (state == B_IDLE) && !q_empty;

  // Way 0 is always in use; a way count above the maximum saturates.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      active[i] = (i == 0) || (int'(cfg.ways) > i);
    end
  end

  always_comb begin
    ev_hit    = 1'b0;
    found_inv = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    lru_way   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!ev_hit && active[i] && valid_row[i] && (tag_row[i] == cur_tag)) begin
        ev_hit  = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!found_inv && active[i] && !valid_row[i]) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (active[i] && (rank_row[i] > rank_row[lru_way])) lru_way = WAY_W'(i);
    end
    ev_way   = ev_hit ? hit_way : (found_inv ? inv_way : lru_way);
    old_rank = valid_row[ev_way] ? OLD_W'(rank_row[ev_way]) : OLD_W'(MAX_WAYS);
    for (int i = 0; i < MAX_WAYS; i++) begin
      new_tag[i]   = tag_row[i];
      new_valid[i] = valid_row[i];
      new_rank[i]  = rank_row[i];
      if (WAY_W'(i) == ev_way) begin
        new_tag[i]   = cur_tag;
        new_valid[i] = 1'b1;
        new_rank[i]  = '0;
      end else if (active[i] && valid_row[i] && (OLD_W'(rank_row[i]) < old_rank)
                   && (rank_row[i] != RANK_MAX)) begin
        new_rank[i] = rank_row[i] + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      tag_row   <= tag_mem[q_set];
      valid_row <= valid_mem[q_set];
      rank_row  <= rank_mem[q_set];
    end
    if (state == B_CLEAR) begin
      valid_mem[clear_cnt] <= '0;
      rank_mem[clear_cnt]  <= '0;
    end else if (state == B_EVAL) begin
      tag_mem[cur_set]   <= new_tag;
      valid_mem[cur_set] <= new_valid;
      rank_mem[cur_set]  <= new_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_set <= q_set;
      cur_tag <= q_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clear_cnt <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_CLEAR: begin
          clear_cnt <= clear_cnt + SET_W'(1);
          if (clear_cnt == SET_W'(MAX_SETS - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) state <= B_EVAL;
        end
        B_EVAL: begin
          done       <= 1'b1;
          hit        <= ev_hit;
          set_number <= cur_set;
          way_number <= ev_way;
          state      <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_no_word_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done)
    else $error("result word during clearing pass");

  a_way_in_use: assert property (@(posedge clk) disable iff (rst)
    done |-> active[way_number])
    else $error("reported way is not in use");

  a_fill_prefers_invalid: assert property (@(posedge clk) disable iff (rst)
    ((state == B_EVAL) && !ev_hit && ((~valid_row & active) != '0))
      |-> !valid_row[ev_way])
    else $error("fill replaced a valid line while an invalid way was free");

endmodule
`default_nettype wire

FILE: rtl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative LRU tag store: APB register block,
// front end, queue and back end. Uses salc_pkg, salc_front, salc_queue and salc_back.
//
// Usage: raise start with word_address while busy is low; the word is taken
// at that clock edge. Each word produces exactly one result word: done is
// high for one cycle with hit, set_number and way_number. The receiver
// cannot stall, so results are never held back.
// The front end stays busy for each word while the address goes twice
// through one bit-per-cycle divider (by the block size, then by the set
// count); that divider sets the throughput. The back end reads the set
// row, then writes the update, and works from a two-entry queue, so it
// overlaps with the next division.
// Reset: registers return to one way, 64 sets, one word per block, and the
// back end runs a clearing pass over all MAX_SETS rows of the valid and age
// memories; busy stays high until it ends. Configuration writes are taken
// at any time but belong only to idle periods.
`default_nettype none
module set_assoc_lru_cache_lookup
  import salc_pkg::*;
#(
  parameter int MAX_SETS  = DEF_MAX_SETS,
  parameter int MAX_WAYS  = DEF_MAX_WAYS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
  parameter int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ADDR_BITS-1:0] word_address,
  output logic                      done,
  output logic                      hit,
  output logic [SET_W-1:0]          set_number,
  output logic [WAY_W-1:0]          way_number,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  cfg_t                  cfg;
  reg_idx_t              reg_idx;
  logic                  wr_en;
  logic                  front_busy;
  logic                  clearing;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [ADDR_BITS-1:0]  f_tag;
  logic [SET_W-1:0]      f_set;
  logic [ADDR_BITS+SET_W-1:0] q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes keep only the register's own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ways <= WAYS_RESET;
      cfg.sets <= SETS_RESET;
      cfg.wpb  <= WPB_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WAYS: cfg.ways <= pwdata[WAYS_CFG_W-1:0];
        REG_SETS: cfg.sets <= pwdata[SETS_CFG_W-1:0];
        REG_WPB:  cfg.wpb  <= pwdata[WPB_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WAYS: prdata = PDATA_W'(cfg.ways);
      REG_SETS: prdata = PDATA_W'(cfg.sets);
      REG_WPB:  prdata = PDATA_W'(cfg.wpb);
      default:  prdata = '0;
    endcase
  end

  // A new word waits out the divider, a full queue and the clearing pass.
  assign busy = front_busy || clearing;

  salc_front #(
    .MAX_SETS  (MAX_SETS),
    .ADDR_BITS (ADDR_BITS),
    .SET_W     (SET_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .hold         (clearing),
    .word_address (word_address),
    .cfg          (cfg),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tag        (f_tag),
    .q_set        (f_set),
    .front_busy   (front_busy)
  );

  salc_queue #(.WIDTH(ADDR_BITS + SET_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_tag, f_set}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  salc_back #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .SET_W     (SET_W),
    .WAY_W     (WAY_W)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_tag      (q_head[ADDR_BITS+SET_W-1:SET_W]),
    .q_set      (q_head[SET_W-1:0]),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .done       (done),
    .hit        (hit),
    .set_number (set_number),
    .way_number (way_number)
  );

endmodule
`default_nettype wire

FILE: tb/salc_checker.sv
// Scoreboard for the set-associative LRU tag store: watches the APB port, the
// lookup channel and the result strobe. Depends on salc_pkg only.
`default_nettype none
module salc_checker
  import salc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [30:0]          word_address,
  input  wire logic                 done,
  input  wire logic                 hit,
  input  wire logic [5:0]           set_number,
  input  wire logic [2:0]           way_number,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  input  wire logic                 pready,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int NSETS = 64;
  localparam int NWAYS = 8;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic       hit;
    logic [5:0] set_no;
    logic [2:0] way_no;
  } lookup_t;

  logic [30:0] tag_mem  [NSETS][NWAYS];
  logic        valid_mem[NSETS][NWAYS];
  logic [2:0]  rank_mem [NSETS][NWAYS];

  logic [WAYS_CFG_W-1:0] ways_reg;
  logic [SETS_CFG_W-1:0] sets_reg;
  logic [WPB_CFG_W-1:0]  wpb_reg;

  // Expected words in order, as a ring with free-running write and read counts.
  lookup_t     exp_fifo [EXP_DEPTH];
  int unsigned exp_wr;
  int unsigned exp_rd;

  // Predicts one lookup, queues its result and updates the shadow tag store.
  task automatic predict_lookup(input logic [30:0] addr);
    int unsigned ways, sets, wpb, blk, set_i, tag, way, old_rank;
    bit found;
    lookup_t res;
    ways = (ways_reg == 0) ? 1 : (ways_reg > NWAYS) ? NWAYS : ways_reg;
    sets = (sets_reg == 0) ? 1 : (sets_reg > NSETS) ? NSETS : sets_reg;
    wpb  = (wpb_reg == 0) ? 1 : wpb_reg;
    blk   = addr / wpb;
    set_i = blk % sets;
    tag   = blk / sets;
    found = 0;
    way   = 0;
    for (int i = 0; i < ways; i++) begin
      if (!found && valid_mem[set_i][i] && tag_mem[set_i][i] == tag[30:0]) begin
        found = 1;
        way = i;
      end
    end
    res.hit = found;
    if (!found) begin
      // Lowest invalid way first, else the oldest line with ties to the lowest.
      way = ways;
      for (int i = ways - 1; i >= 0; i--) begin
        if (!valid_mem[set_i][i]) way = i;
      end
      if (way == ways) begin
        way = 0;
        for (int i = 1; i < ways; i++) begin
          if (rank_mem[set_i][i] > rank_mem[set_i][way]) way = i;
        end
      end
    end
    old_rank = valid_mem[set_i][way] ? rank_mem[set_i][way] : NWAYS;
    for (int i = 0; i < ways; i++) begin
      if (i != way && valid_mem[set_i][i] && rank_mem[set_i][i] < old_rank &&
          rank_mem[set_i][i] < NWAYS - 1) begin
        rank_mem[set_i][i] = rank_mem[set_i][i] + 1;
      end
    end
    valid_mem[set_i][way] = 1;
    tag_mem[set_i][way]   = tag[30:0];
    rank_mem[set_i][way]  = 0;
    res.set_no = set_i[5:0];
    res.way_no = way[2:0];
    exp_fifo[exp_wr % EXP_DEPTH] = res;
    exp_wr = exp_wr + 1;
  endtask

  always @(posedge clk) begin
    lookup_t exp_res;
    if (rst) begin
      for (int s = 0; s < NSETS; s++) begin
        for (int w = 0; w < NWAYS; w++) begin
          valid_mem[s][w] = 0;
          rank_mem[s][w]  = 0;
          tag_mem[s][w]   = 0;
        end
      end
      ways_reg = WAYS_RESET;
      sets_reg = SETS_RESET;
      wpb_reg  = WPB_RESET;
      exp_wr = 0;
      exp_rd = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_WAYS: ways_reg = pwdata[WAYS_CFG_W-1:0];
          REG_SETS: sets_reg = pwdata[SETS_CFG_W-1:0];
          REG_WPB:  wpb_reg  = pwdata[WPB_CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (start && !busy) predict_lookup(word_address);
      if (done) begin
        if (exp_wr == exp_rd) begin
          if (mismatches < 10)
            $display("unexpected result word: hit=%0d set=%0d way=%0d",
                     hit, set_number, way_number);
          mismatches <= mismatches + 1;
        end else begin
          exp_res = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd = exp_rd + 1;
          if (exp_res.hit !== hit || exp_res.set_no !== set_number ||
              exp_res.way_no !== way_number) begin
            if (mismatches < 10)
              $display("result mismatch: expected hit=%0d set=%0d way=%0d, got %0d %0d %0d",
                       exp_res.hit, exp_res.set_no, exp_res.way_no,
                       hit, set_number, way_number);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= int'(exp_wr - exp_rd);
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb_set_assoc_lru_cache_lookup.sv
// Top of the tag store testbench: clock, reset, APB setup, lookup stimulus,
// watchdog and verdict. Depends on salc_pkg, salc_checker and the block.
`default_nettype none
module tb_set_assoc_lru_cache_lookup;
  import salc_pkg::*;

  // No accepted word, strobe or register write for this long means a hang.
  localparam int QUIET_LIMIT = 4000;
  // Drain wait, longer than the block takes for one word.
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_PER_SETTING = 80;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [30:0] word_address = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic busy, done, hit, pready;
  logic [5:0] set_number;
  logic [2:0] way_number;
  logic [PDATA_W-1:0] prdata;
  int mismatches, outstanding;
  int quiet_cycles = 0;

  // Effective geometry, kept here so that random addresses aim at real sets.
  int unsigned eff_ways = 1, eff_sets = 64, eff_wpb = 1;
  bit gaps_enabled = 1;

  always #4 clk = ~clk;

  set_assoc_lru_cache_lookup dut (
    .clk, .rst, .start, .busy, .word_address, .done, .hit, .set_number,
    .way_number, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  salc_checker u_checker (
    .clk, .rst, .start, .busy, .word_address, .done, .hit, .set_number,
    .way_number, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .outstanding
  );

  // Sends one lookup word and returns right after the edge that takes it.
  // While the word waits, start drops at random in about a third of the
  // cycles when gaps are enabled.
  task automatic send_lookup(input logic [30:0] addr);
    bit taken;
    taken = 0;
    word_address <= addr;
    while (!taken) begin
      start <= !(gaps_enabled && ($urandom_range(0, 99) < 36));
      @(posedge clk);
      taken = start && !busy;
    end
  endtask

  // Setup and access phase of an APB write; the register takes it at the
  // edge that ends the access phase.
  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Reconfigures only once every result has come back and the back end
  // has had time to finish its last update.
  task automatic set_geometry(input int unsigned ways, input int unsigned sets,
                              input int unsigned wpb);
    start <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_WAYS, ways);
    write_reg(REG_SETS, sets);
    write_reg(REG_WPB, wpb);
    eff_ways = (ways == 0) ? 1 : (ways > 8) ? 8 : ways;
    eff_sets = (sets == 0) ? 1 : (sets > 64) ? 64 : sets;
    eff_wpb  = (wpb == 0) ? 1 : wpb;
  endtask

  // Mostly addresses built from a few sets and a few more tags than there
  // are ways, so lines hit, fill and get evicted; the rest is raw noise.
  task automatic random_lookups(input int count);
    longint unsigned blk, addr;
    int unsigned set_i;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 80) begin
        set_i = $urandom_range(0, (eff_sets > 4) ? 3 : eff_sets - 1);
        if ($urandom_range(0, 9) == 0) set_i = $urandom_range(0, eff_sets - 1);
        blk = longint'($urandom_range(0, eff_ways + 2)) * eff_sets + set_i;
        addr = blk * eff_wpb + $urandom_range(0, eff_wpb - 1);
        send_lookup(addr[30:0]);
      end else begin
        send_lookup(31'($urandom()));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;

    // Reset geometry is direct mapped with 64 sets: hits, conflict evictions
    // and the address extremes.
    send_lookup(31'd0);
    send_lookup(31'd0);
    send_lookup(31'h7FFF_FFFF);
    send_lookup(31'h7FFF_FFFF);
    send_lookup(31'd64);
    send_lookup(31'd0);
    send_lookup(31'h2AAA_AAAA);
    send_lookup(31'h5555_5555);
    send_lookup(31'h5555_5555);

    // Eight ways: fill set 0, refresh one line, then force LRU evictions.
    set_geometry(8, 64, 1);
    for (int t = 0; t < 9; t++) send_lookup(31'(t * 64));
    send_lookup(31'(3 * 64));
    send_lookup(31'(10 * 64));
    send_lookup(31'(0));
    random_lookups(RANDOM_PER_SETTING);

    set_geometry(4, 3, 7);
    random_lookups(RANDOM_PER_SETTING);

    // Zero in every register acts as the smallest legal value.
    set_geometry(0, 0, 0);
    random_lookups(RANDOM_PER_SETTING);

    // Oversized associativity and set count, largest block, no gaps at all.
    gaps_enabled = 0;
    set_geometry(15, 127, 65535);
    random_lookups(RANDOM_PER_SETTING);
    gaps_enabled = 1;

    set_geometry(8, 1, 65535);
    random_lookups(RANDOM_PER_SETTING);

    // Fewer ways than before: lines left in the upper ways must be ignored.
    set_geometry(2, 5, 3);
    random_lookups(RANDOM_PER_SETTING);

    start <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
